>>> src/tlblf_pkg.sv
// Shared types and constants for the fully associative TLB with LRU fill.
// Used by every module in src; depends on nothing else.
package tlblf_pkg;

  localparam int VpnW      = 36;
  localparam int PpnW      = 20;
  localparam int OfsW      = 12;
  localparam int NumLines  = 128;
  // Cells merged by one group register when a request transfers.
  localparam int GroupSize = 32;

  localparam logic ReqTranslate   = 1'b0;
  localparam logic ReqFlush       = 1'b1;
  localparam logic StatusOk       = 1'b0;
  localparam logic StatusWalkFail = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [VpnW-1:0] virtual_page;
    logic [OfsW-1:0] byte_offset;
    logic [PpnW-1:0] walk_page;
    logic            walk_ok;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [PpnW-1:0] phys_page;
    logic [OfsW-1:0] offset_out;
    logic            status;
  } rsp_t;

  // Match report of one cell or one group; page is zero where nothing matched.
  typedef struct packed {
    logic            hit;
    logic [PpnW-1:0] page;
  } probe_t;

  // Update command broadcast to the cell row at the end of an item.
  typedef struct packed {
    logic flush;
    logic touch;
    logic fill;
  } upd_t;

endpackage

>>> src/tlblf_cell.sv
// One TLB line: tag, valid, physical page and its LRU rank (0 = least recent).
// Depends on tlblf_pkg.
module tlblf_cell #(
  parameter int NUM_LINES  = tlblf_pkg::NumLines,
  parameter int RANK_W     = $clog2(tlblf_pkg::NumLines),
  parameter int RESET_RANK = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tlblf_pkg::VpnW-1:0]  lookup_vpn_i,
  input  tlblf_pkg::upd_t             upd_i,
  input  logic [RANK_W-1:0]           upd_rank_i,
  input  logic [tlblf_pkg::VpnW-1:0]  fill_vpn_i,
  input  logic [tlblf_pkg::PpnW-1:0]  fill_page_i,
  output tlblf_pkg::probe_t           probe_o,
  output logic [RANK_W-1:0]           rank_o
);

  localparam logic [RANK_W-1:0] LastRank  = RANK_W'(NUM_LINES - 1);
  localparam logic [RANK_W-1:0] ResetRank = RANK_W'(RESET_RANK);

  logic                        valid_q, valid_d;
  logic [RANK_W-1:0]           rank_q, rank_d;
  logic [tlblf_pkg::VpnW-1:0]  tag_q, tag_d;
  logic [tlblf_pkg::PpnW-1:0]  page_q, page_d;
  logic                        match;
  logic                        victim;

  assign match        = valid_q && (tag_q == lookup_vpn_i);
  assign victim       = (rank_q == '0);
  assign probe_o.hit  = match;
  assign probe_o.page = match ? page_q : '0;
  assign rank_o       = match ? rank_q : '0;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    tag_d   = tag_q;
    page_d  = page_q;
    if (upd_i.flush) begin
      valid_d = 1'b0;
    end
    // Touched line goes to most recent; lines above it step down one.
    if (upd_i.touch) begin
      if (rank_q == upd_rank_i) begin
        rank_d = LastRank;
      end else if (rank_q > upd_rank_i) begin
        rank_d = rank_q - 1'b1;
      end
    end
    if (upd_i.fill && victim) begin
      tag_d   = fill_vpn_i;
      page_d  = fill_page_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= ResetRank;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    page_q <= page_d;
  end

endmodule

>>> src/tlblf_merge.sv
// Group merge register: ORs the match reports of a run of cells and holds
// the result for the update cycle. Depends on tlblf_pkg.
module tlblf_merge #(
  parameter int CELLS  = tlblf_pkg::GroupSize,
  parameter int RANK_W = $clog2(tlblf_pkg::NumLines)
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  tlblf_pkg::probe_t [CELLS-1:0]       probe_i,
  input  logic [CELLS-1:0][RANK_W-1:0]        rank_i,
  output tlblf_pkg::probe_t                   probe_o,
  output logic [RANK_W-1:0]                   rank_o
);

  tlblf_pkg::probe_t probe_q, probe_d;
  logic [RANK_W-1:0] rank_q, rank_d;

  // Unmatched cells report zeros, so a plain OR picks the matching line.
  always_comb begin
    probe_d = '0;
    rank_d  = '0;
    for (int c = 0; c < CELLS; c++) begin
      probe_d.hit  = probe_d.hit | probe_i[c].hit;
      probe_d.page = probe_d.page | probe_i[c].page;
      rank_d       = rank_d | rank_i[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      probe_q <= probe_d;
      rank_q  <= rank_d;
    end
  end

  assign probe_o = probe_q;
  assign rank_o  = rank_q;

endmodule

>>> src/tlb_lookup_lru_fill.sv
// Top level of the fully associative TLB with true LRU fill.
// Depends on tlblf_pkg, tlblf_cell and tlblf_merge.
//
// Usage: drive req_i and raise start_i; the request transfers at the clock
// edge where start_i is high and busy_o is low. busy_o is then high for
// exactly one cycle, and the result appears on rsp_o with done_o high for
// exactly one cycle after that. The receiver cannot stall: capture rsp_o in
// the cycle done_o is high. A new start is taken in that same cycle, while
// the last result is shown, but never while busy_o is high. In the transfer
// cycle every cell compares its tag to the page number and the group registers
// fold the matches; in the busy cycle the groups are combined, the LRU ranks
// and line contents updated, and the result registered. No clearing pass
// follows reset: valid bits and LRU ranks reset in place, so the first
// request may start right after reset is released.
module tlb_lookup_lru_fill #(
  parameter int NUM_LINES = tlblf_pkg::NumLines
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tlblf_pkg::req_t   req_i,
  output logic              done_o,
  output tlblf_pkg::rsp_t   rsp_o
);

  localparam int RankW     = $clog2(NUM_LINES);
  localparam int NumGroups = (NUM_LINES + tlblf_pkg::GroupSize - 1) / tlblf_pkg::GroupSize;

  // Handshake and sequencing.
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic accept;

  // Request held for the update cycle.
  tlblf_pkg::req_t req_q;

  // Cell row and group merge outputs.
  tlblf_pkg::probe_t [NUM_LINES-1:0]            probe_w;
  logic [NUM_LINES-1:0][RankW-1:0]              rank_w;
  tlblf_pkg::probe_t [NumGroups-1:0]            grp_probe_w;
  logic [NumGroups-1:0][RankW-1:0]              grp_rank_w;

  // Combined lookup and decode.
  logic                          any_hit;
  logic [tlblf_pkg::PpnW-1:0]    hit_page;
  logic [RankW-1:0]              hit_rank;
  logic                          is_flush;
  logic                          do_hit;
  logic                          do_fill;
  logic                          walk_fail;
  tlblf_pkg::upd_t               upd;
  logic [RankW-1:0]              upd_rank;
  tlblf_pkg::rsp_t               rsp_q, rsp_d;

  // Take a request only when the row is not mid-update.
  assign accept = start_i && !busy_q;
  assign busy_d = accept;
  assign done_d = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // Row of line cells. Each compares its tag against the incoming page
  // number straight off the port; the groups register the folded result.
  for (genvar k = 0; k < NUM_LINES; k++) begin : g_cell
    tlblf_cell #(
      .NUM_LINES  (NUM_LINES),
      .RANK_W     (RankW),
      .RESET_RANK (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .lookup_vpn_i (req_i.virtual_page),
      .upd_i        (upd),
      .upd_rank_i   (upd_rank),
      .fill_vpn_i   (req_q.virtual_page),
      .fill_page_i  (req_q.walk_page),
      .probe_o      (probe_w[k]),
      .rank_o       (rank_w[k])
    );
  end

  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    localparam int Base = g * tlblf_pkg::GroupSize;
    localparam int Cnt  = (NUM_LINES - Base < tlblf_pkg::GroupSize) ?
                          (NUM_LINES - Base) : tlblf_pkg::GroupSize;
    tlblf_merge #(
      .CELLS  (Cnt),
      .RANK_W (RankW)
    ) u_merge (
      .clk_i   (clk_i),
      .en_i    (accept),
      .probe_i (probe_w[Base +: Cnt]),
      .rank_i  (rank_w[Base +: Cnt]),
      .probe_o (grp_probe_w[g]),
      .rank_o  (grp_rank_w[g])
    );
  end

  // Fill only happens on a miss and flush drops every valid bit, so at most
  // one valid line ever holds a given page number: an OR picks it.
  always_comb begin
    any_hit  = 1'b0;
    hit_page = '0;
    hit_rank = '0;
    for (int g = 0; g < NumGroups; g++) begin
      any_hit  = any_hit | grp_probe_w[g].hit;
      hit_page = hit_page | grp_probe_w[g].page;
      hit_rank = hit_rank | grp_rank_w[g];
    end
  end

  // Decode the held request against the lookup outcome.
  assign is_flush  = (req_q.req_type == tlblf_pkg::ReqFlush);
  assign do_hit    = !is_flush && any_hit;
  assign do_fill   = !is_flush && !any_hit && req_q.walk_ok;
  assign walk_fail = !is_flush && !any_hit && !req_q.walk_ok;

  // Broadcast the update in the busy cycle only. A fill lands on the
  // rank-zero line, so its touch rank is zero.
  assign upd.flush = busy_q && is_flush;
  assign upd.touch = busy_q && (do_hit || do_fill);
  assign upd.fill  = busy_q && do_fill;
  assign upd_rank  = do_hit ? hit_rank : '0;

  always_comb begin
    rsp_d.hit        = do_hit;
    rsp_d.offset_out = req_q.byte_offset;
    rsp_d.status     = walk_fail ? tlblf_pkg::StatusWalkFail : tlblf_pkg::StatusOk;
    if (do_hit) begin
      rsp_d.phys_page = hit_page;
    end else if (do_fill) begin
      rsp_d.phys_page = req_q.walk_page;
    end else begin
      rsp_d.phys_page = '0;
    end
  end

  // Hold the result register until the next update cycle.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> src/tlblf_checker.sv
// Port-level checker for tlb_lookup_lru_fill and the bind that attaches it.
// Depends on tlblf_pkg and the top level's ports.
module tlblf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic            done_o,
  input tlblf_pkg::rsp_t rsp_o
);

  // A transfer starts the update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after transfer");

  // busy_o drops again once the update is done; it is never held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  // Every update yields a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o)
    else $error("result strobe missing after update");

  // A failed walk reports neither a hit nor a page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == tlblf_pkg::StatusWalkFail) |->
      !rsp_o.hit && (rsp_o.phys_page == '0))
    else $error("walk failure reported with hit or page");

endmodule

bind tlb_lookup_lru_fill tlblf_checker u_tlblf_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

>>> tb/tlb_lookup_lru_fill_test.sv
// Self-checking testbench for tlb_lookup_lru_fill: random bursts of translate and flush
// requests, predicted against a behavioral TLB with true LRU order kept in the bench.
// Depends on tlblf_pkg and the RTL in src; needs no files or arguments.
module tlb_lookup_lru_fill_test;
  import tlblf_pkg::*;

  localparam int LineW      = $clog2(NumLines);
  localparam int HotVpns    = 16;
  localparam int PoolVpns   = 160;   // more than NumLines so that fills evict
  localparam int RandItems  = 900;
  localparam int CycleLimit = 200000;
  localparam int ReportMax  = 10;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  // Requests still to be driven, and the translations still to come back.
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  // Shadow copy of the TLB contents and of the LRU order (position 0 least recent).
  logic [VpnW-1:0]  shadow_tag   [NumLines];
  logic             shadow_valid [NumLines];
  logic [PpnW-1:0]  shadow_page  [NumLines];
  logic [LineW-1:0] shadow_lru   [NumLines];

  logic [VpnW-1:0] vpn_pool [PoolVpns];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;

  tlb_lookup_lru_fill u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  // Move a line to the most recent end of the LRU order.
  function automatic void promote_line(input logic [LineW-1:0] line);
    int pos;
    pos = 0;
    while (pos < NumLines && shadow_lru[pos] != line) pos++;
    if (pos < NumLines) begin
      for (int k = pos; k + 1 < NumLines; k++) shadow_lru[k] = shadow_lru[k + 1];
      shadow_lru[NumLines - 1] = line;
    end
  endfunction

  // Work out the response to one request and apply its effect on the shadow TLB.
  function automatic rsp_t translate_and_update(input req_t r);
    rsp_t             o;
    int               hit_line;
    logic [LineW-1:0] victim;
    o            = '0;
    o.offset_out = r.byte_offset;
    o.status     = StatusOk;
    if (r.req_type == ReqFlush) begin
      // Flush wipes contents but leaves the LRU order alone.
      for (int k = 0; k < NumLines; k++) begin
        shadow_tag[k]   = '0;
        shadow_valid[k] = 1'b0;
        shadow_page[k]  = '0;
      end
    end else begin
      // Scan downward so the lowest matching line wins.
      hit_line = -1;
      for (int k = NumLines - 1; k >= 0; k--)
        if (shadow_valid[k] && shadow_tag[k] == r.virtual_page) hit_line = k;
      if (hit_line >= 0) begin
        o.hit       = 1'b1;
        o.phys_page = shadow_page[hit_line];
        promote_line(LineW'(hit_line));
      end else if (r.walk_ok) begin
        victim               = shadow_lru[0];
        shadow_tag[victim]   = r.virtual_page;
        shadow_page[victim]  = r.walk_page;
        shadow_valid[victim] = 1'b1;
        promote_line(victim);
        o.phys_page = r.walk_page;
      end else begin
        o.status = StatusWalkFail;
      end
    end
    return o;
  endfunction

  function automatic req_t make_req(input logic kind, input logic [VpnW-1:0] vpn,
                                    input logic [OfsW-1:0] ofs, input logic [PpnW-1:0] wpage,
                                    input logic ok);
    req_t r;
    r.req_type     = kind;
    r.virtual_page = vpn;
    r.byte_offset  = ofs;
    r.walk_page    = wpage;
    r.walk_ok      = ok;
    return r;
  endfunction

  function automatic logic [VpnW-1:0] random_vpn();
    return {4'($urandom_range(0, 15)), 32'($urandom)};
  endfunction

  task automatic report_error(input string what, input rsp_t want, input rsp_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportMax)
      $display({"%s: expected hit=%0d page=%05h ofs=%03h st=%0d, ",
                "got hit=%0d page=%05h ofs=%03h st=%0d"},
               what, want.hit, want.phys_page, want.offset_out, want.status,
               got.hit, got.phys_page, got.offset_out, got.status);
  endtask

  // Driver: the request transfers at an edge with start high and busy low. Predict it
  // there, then present the next request unless a gap is running. Hold the current
  // request while busy; start gets at most one assignment per edge.
  always @(posedge clk_i) begin : drive_proc
    logic next_start;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) expected_rsps.push_back(translate_and_update(req_i));
      if (!(start_i && busy_o)) begin
        next_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          req_i      <= pending_reqs.pop_front();
          next_start = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            // New burst: some bursts run back to back, others leave a short gap.
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
        start_i <= next_start;
      end
    end
  end

  // Monitor: the result is valid for exactly the cycle done is high; take it at the
  // edge that ends that cycle and match it against the oldest expectation.
  always @(posedge clk_i) begin : check_proc
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        report_error("unexpected result", '0, rsp_o);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_o.hit !== want.hit || rsp_o.phys_page !== want.phys_page ||
            rsp_o.offset_out !== want.offset_out || rsp_o.status !== want.status)
          report_error("result mismatch", want, rsp_o);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stim_proc
    int              pick;
    logic [VpnW-1:0] vpn;
    for (int k = 0; k < NumLines; k++) begin
      shadow_tag[k]   = '0;
      shadow_valid[k] = 1'b0;
      shadow_page[k]  = '0;
      shadow_lru[k]   = LineW'(k);
    end
    for (int k = 0; k < PoolVpns; k++) vpn_pool[k] = random_vpn();

    // Directed part. Page zero must miss on an empty TLB, whatever the tags hold after reset.
    pending_reqs.push_back(make_req(ReqTranslate, '0, '0, '1, 1'b0));       // walk fails
    pending_reqs.push_back(make_req(ReqTranslate, '0, '1, '1, 1'b1));       // fill
    pending_reqs.push_back(make_req(ReqTranslate, '0, 12'h5a5, '0, 1'b0));  // hit, walk ignored
    pending_reqs.push_back(make_req(ReqTranslate, '1, '0, '0, 1'b1));       // fill max page
    pending_reqs.push_back(make_req(ReqTranslate, '1, '1, 20'h12345, 1'b1)); // hit, walk ignored
    pending_reqs.push_back(make_req(ReqTranslate, 36'h800000001, 12'h001, 20'h80000, 1'b0));
    pending_reqs.push_back(make_req(ReqTranslate, 36'h800000001, 12'h800, 20'h80001, 1'b1));
    pending_reqs.push_back(make_req(ReqTranslate, 36'h800000001, 12'h7ff, 20'h00000, 1'b1));
    // Flush with busy payload fields: they must not leak into the result.
    pending_reqs.push_back(make_req(ReqFlush, '1, 12'habc, '1, 1'b1));
    pending_reqs.push_back(make_req(ReqTranslate, '1, 12'h123, 20'h0000f, 1'b0)); // gone
    pending_reqs.push_back(make_req(ReqTranslate, '0, 12'h456, 20'hf0000, 1'b1)); // refill
    pending_reqs.push_back(make_req(ReqTranslate, '0, 12'hfff, 20'h55555, 1'b1)); // hit
    pending_reqs.push_back(make_req(ReqFlush, '0, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(ReqTranslate, '0, '0, '0, 1'b1));       // zero page fill
    pending_reqs.push_back(make_req(ReqTranslate, '0, '0, 20'hfffff, 1'b0)); // hit zero page

    // Random part: a hot set that keeps getting touched, a wider pool that overflows the
    // TLB and forces LRU evictions, some fresh pages, and the odd flush.
    for (int i = 0; i < RandItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        pending_reqs.push_back(make_req(ReqFlush, random_vpn(), 12'($urandom),
                                        20'($urandom), 1'($urandom)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) vpn = vpn_pool[$urandom_range(0, HotVpns - 1)];
        else if (pick < 90) vpn = vpn_pool[$urandom_range(0, PoolVpns - 1)];
        else vpn = random_vpn();
        pending_reqs.push_back(make_req(ReqTranslate, vpn, 12'($urandom), 20'($urandom),
                                        $urandom_range(0, 9) != 0));
      end
    end

    // Hold reset, then release it once.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: wait until every request has transferred and every result has come back.
    while (pending_reqs.size() > 0 || start_i || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> tlb_lookup_lru_fill.f
src/tlblf_pkg.sv
src/tlblf_cell.sv
src/tlblf_merge.sv
src/tlb_lookup_lru_fill.sv
src/tlblf_checker.sv
tb/tlb_lookup_lru_fill_test.sv
